@@ rtl/mlt_pkg.sv @@
// Shared constants, command and status codes, and chain transfer types of the MAC table.
`default_nettype none

package mlt_pkg;

   localparam int MAC_W                 = 48;
   localparam int PORT_W                = 32;
   localparam int MCAST_BIT             = 40;
   localparam int TABLE_ENTRIES_DEFAULT = 64;
   localparam int IDX_W_DEFAULT         = $clog2(TABLE_ENTRIES_DEFAULT);

   localparam logic [PORT_W-1:0] FLOOD_PORT_RESET = 32'hFFFF_FFFB;

   localparam logic [1:0] CMD_FRAME  = 2'd0;
   localparam logic [1:0] CMD_EXPIRE = 2'd1;
   localparam logic [1:0] CMD_CLEAR  = 2'd2;

   localparam logic [2:0] ST_HIT       = 3'd0;
   localparam logic [2:0] ST_MISS      = 3'd1;
   localparam logic [2:0] ST_SRC_MCAST = 3'd2;
   localparam logic [2:0] ST_DST_MCAST = 3'd3;
   localparam logic [2:0] ST_DONE      = 3'd4;

   // Search token that walks the row of cells, one cell per cycle.
   typedef struct packed {
      logic              active;
      logic              src_hit;
      logic              dst_hit;
      logic              f1_ok;
      logic              f2_ok;
      logic [PORT_W-1:0] dst_port;
   } tok_type;

   // Broadcast write-back; entry indexes travel beside it.
   typedef struct packed {
      logic              a_set;
      logic              a_kill;
      logic              b_set;
      logic              clear_all;
      logic [MAC_W-1:0]  a_mac;
      logic [PORT_W-1:0] a_port;
      logic [MAC_W-1:0]  b_mac;
      logic [PORT_W-1:0] b_port;
   } wr_type;

endpackage

`default_nettype wire

@@ rtl/mlt_cell.sv @@
// One table entry with its own comparators and one stage of the search token.
`default_nettype none

module mlt_cell
   import mlt_pkg::*;
#(
   parameter int IDX_W      = IDX_W_DEFAULT,
   parameter int CELL_INDEX = 0
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [MAC_W-1:0]  src_key,
   input  wire logic [MAC_W-1:0]  dst_key,
   input  wire tok_type           prev_tok,
   input  wire logic [IDX_W-1:0]  prev_src_idx,
   input  wire logic [IDX_W-1:0]  prev_f1_idx,
   input  wire logic [IDX_W-1:0]  prev_f2_idx,
   output tok_type                next_tok,
   output logic      [IDX_W-1:0]  next_src_idx,
   output logic      [IDX_W-1:0]  next_f1_idx,
   output logic      [IDX_W-1:0]  next_f2_idx,
   input  wire wr_type            wr,
   input  wire logic [IDX_W-1:0]  wr_a_idx,
   input  wire logic [IDX_W-1:0]  wr_b_idx
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

   logic              valid_ff;
   logic [MAC_W-1:0]  mac_ff;
   logic [PORT_W-1:0] port_ff;

   tok_type           tok_ff, tok_in;
   logic [IDX_W-1:0]  src_idx_ff, src_idx_in;
   logic [IDX_W-1:0]  f1_idx_ff, f1_idx_in;
   logic [IDX_W-1:0]  f2_idx_ff, f2_idx_in;

   logic src_match, dst_match, a_sel, b_sel;

   assign src_match = valid_ff && (mac_ff == src_key);
   assign dst_match = valid_ff && (mac_ff == dst_key);
   assign a_sel     = (wr_a_idx == MY_IDX);
   assign b_sel     = (wr_b_idx == MY_IDX);

   // fold this entry into the passing token
   always_comb begin
      tok_in     = prev_tok;
      src_idx_in = prev_src_idx;
      f1_idx_in  = prev_f1_idx;
      f2_idx_in  = prev_f2_idx;
      if (prev_tok.active) begin
         if (src_match && !prev_tok.src_hit) begin
            tok_in.src_hit = 1'b1;
            src_idx_in     = MY_IDX;
         end
         if (dst_match && !prev_tok.dst_hit) begin
            tok_in.dst_hit  = 1'b1;
            tok_in.dst_port = port_ff;
         end
         if (!valid_ff) begin
            if (!prev_tok.f1_ok) begin
               tok_in.f1_ok = 1'b1;
               f1_idx_in    = MY_IDX;
            end else if (!prev_tok.f2_ok) begin
               tok_in.f2_ok = 1'b1;
               f2_idx_in    = MY_IDX;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.active <= 1'b0;
      end else begin
         tok_ff     <= tok_in;
         src_idx_ff <= src_idx_in;
         f1_idx_ff  <= f1_idx_in;
         f2_idx_ff  <= f2_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (wr.clear_all) begin
         valid_ff <= 1'b0;
      end else if (wr.a_kill && a_sel) begin
         valid_ff <= 1'b0;
      end else if ((wr.a_set && a_sel) || (wr.b_set && b_sel)) begin
         valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.a_set && a_sel) begin
         mac_ff  <= wr.a_mac;
         port_ff <= wr.a_port;
      end else if (wr.b_set && b_sel) begin
         mac_ff  <= wr.b_mac;
         port_ff <= wr.b_port;
      end
   end

   assign next_tok     = tok_ff;
   assign next_src_idx = src_idx_ff;
   assign next_f1_idx  = f1_idx_ff;
   assign next_f2_idx  = f2_idx_ff;

endmodule

`default_nettype wire

@@ rtl/mac_learning_table.sv @@
// Top level of the MAC learning and forwarding table: sequencer and row of entry cells.
//
// Usage: one request channel (req_*) carries a command with its addresses and
// ingress port; one response channel (rsp_*) returns a transaction per request
// with the egress port, a status code and the learn/remove/full flags. The
// flood port register is written through csr_valid/csr_ready/csr_flood_port,
// which is always ready; write it only while the block is idle.
// Frame and expire commands send a search token down the row of
// TABLE_ENTRIES cells, one cell per clock; the token leaving the last cell is
// captured, then the write-back of up to two entries and the response
// register are loaded together. Clear, a multicast source and the unused
// command skip the walk and go straight to the write-back.
// Reset empties the table at once (valid bits only) and restores the flood
// port to its default. A stalled response holds; the next request is still
// taken, but its write-back waits until the response register is free.
`default_nettype none

module mac_learning_table
   import mlt_pkg::*;
#(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // request channel
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [1:0]        req_cmd,
   input  wire logic [MAC_W-1:0]  req_dst_mac,
   input  wire logic [MAC_W-1:0]  req_src_mac,
   input  wire logic [PORT_W-1:0] req_in_port,
   input  wire logic [MAC_W-1:0]  req_expire_mac,
   // response channel
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic      [PORT_W-1:0] rsp_out_port,
   output logic      [2:0]        rsp_status,
   output logic                   rsp_src_added,
   output logic                   rsp_dst_added,
   output logic                   rsp_removed,
   output logic                   rsp_table_full,
   // flood port register
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [PORT_W-1:0] csr_flood_port
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);

   typedef enum logic [1:0] {S_IDLE, S_SWEEP, S_WRITE} state_type;

   state_type         state_ff;
   logic              launch_ff;
   logic [1:0]        cmd_ff;
   logic [MAC_W-1:0]  key_a_ff;   // source MAC, or the MAC to expire
   logic [MAC_W-1:0]  dst_ff;
   logic [PORT_W-1:0] in_port_ff;
   logic [PORT_W-1:0] flood_ff;

   tok_type           res_ff;
   logic [IDX_W-1:0]  res_src_idx_ff, res_f1_ff, res_f2_ff;

   logic              rsp_valid_ff;
   logic [PORT_W-1:0] rsp_out_port_ff;
   logic [2:0]        rsp_status_ff;
   logic              rsp_src_added_ff, rsp_dst_added_ff, rsp_removed_ff, rsp_full_ff;

   // search chain: element i feeds cell i
   tok_type           tok     [TABLE_ENTRIES+1];
   logic [IDX_W-1:0]  src_idx [TABLE_ENTRIES+1];
   logic [IDX_W-1:0]  f1_idx  [TABLE_ENTRIES+1];
   logic [IDX_W-1:0]  f2_idx  [TABLE_ENTRIES+1];
   logic [TABLE_ENTRIES-1:0] tok_active;

   wr_type            wr;
   logic [IDX_W-1:0]  wr_a_idx, wr_b_idx;
   logic              commit;
   logic              need_sweep;

   logic [PORT_W-1:0] res_out_port;
   logic [2:0]        res_status;
   logic              res_src_added, res_dst_added, res_removed, res_full;

   logic              src_learned, src_new, same_mac;

   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   // write-back may proceed once the response register can take the result
   assign commit = (state_ff == S_WRITE) && (!rsp_valid_ff || !rsp_stall);

   assign need_sweep = ((req_cmd == CMD_FRAME) && !req_src_mac[MCAST_BIT])
                       || (req_cmd == CMD_EXPIRE);

   // inject a fresh token into the first cell
   always_comb begin
      tok[0]        = '0;
      tok[0].active = launch_ff;
      src_idx[0]    = '0;
      f1_idx[0]     = '0;
      f2_idx[0]     = '0;
   end

   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      mlt_cell #(
         .IDX_W      (IDX_W),
         .CELL_INDEX (i)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .src_key      (key_a_ff),
         .dst_key      (dst_ff),
         .prev_tok     (tok[i]),
         .prev_src_idx (src_idx[i]),
         .prev_f1_idx  (f1_idx[i]),
         .prev_f2_idx  (f2_idx[i]),
         .next_tok     (tok[i+1]),
         .next_src_idx (src_idx[i+1]),
         .next_f1_idx  (f1_idx[i+1]),
         .next_f2_idx  (f2_idx[i+1]),
         .wr           (wr),
         .wr_a_idx     (wr_a_idx),
         .wr_b_idx     (wr_b_idx)
      );
      assign tok_active[i] = tok[i+1].active;
   end

   // Resolve the finished search into write-back and response.
   // Port A learns the source (or drops the expired entry); port B inserts a
   // missing destination into the first free entry the source has not taken.
   assign src_learned = res_ff.src_hit || res_ff.f1_ok;
   assign src_new     = !res_ff.src_hit && res_ff.f1_ok;
   assign same_mac    = (dst_ff == key_a_ff);

   always_comb begin
      wr            = '0;
      wr_a_idx      = '0;
      wr_b_idx      = '0;
      res_out_port  = '0;
      res_status    = ST_DONE;
      res_src_added = 1'b0;
      res_dst_added = 1'b0;
      res_removed   = 1'b0;
      res_full      = 1'b0;
      wr.a_mac      = key_a_ff;
      wr.a_port     = in_port_ff;
      wr.b_mac      = dst_ff;
      wr.b_port     = flood_ff;
      case (cmd_ff)
         CMD_FRAME: begin
            if (key_a_ff[MCAST_BIT]) begin
               res_status = ST_SRC_MCAST;
            end else begin
               wr.a_set      = src_learned;
               wr_a_idx      = res_ff.src_hit ? res_src_idx_ff : res_f1_ff;
               res_src_added = src_new;
               res_full      = !src_learned;
               if (dst_ff[MCAST_BIT]) begin
                  res_status = ST_DST_MCAST;
               end else if (same_mac && src_learned) begin
                  // destination is the source just learned
                  res_out_port = in_port_ff;
                  res_status   = ST_HIT;
               end else if (!same_mac && res_ff.dst_hit) begin
                  res_out_port = res_ff.dst_port;
                  res_status   = ST_HIT;
               end else begin
                  res_out_port = flood_ff;
                  res_status   = ST_MISS;
                  // skip the free entry the source has just taken
                  if (src_new) begin
                     wr.b_set = res_ff.f2_ok;
                     wr_b_idx = res_f2_ff;
                  end else begin
                     wr.b_set = res_ff.f1_ok;
                     wr_b_idx = res_f1_ff;
                  end
                  res_dst_added = wr.b_set;
                  if (!wr.b_set) begin
                     res_full = 1'b1;
                  end
               end
            end
         end
         CMD_EXPIRE: begin
            wr.a_kill   = res_ff.src_hit;
            wr_a_idx    = res_src_idx_ff;
            res_removed = res_ff.src_hit;
         end
         CMD_CLEAR: begin
            wr.clear_all = 1'b1;
         end
         default: begin
         end
      endcase
      // hold the table untouched until the response register is free
      wr.a_set     = wr.a_set     && commit;
      wr.a_kill    = wr.a_kill    && commit;
      wr.b_set     = wr.b_set     && commit;
      wr.clear_all = wr.clear_all && commit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         launch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         flood_ff     <= FLOOD_PORT_RESET;
      end else begin
         // fire a token only as a search request is taken
         launch_ff <= (state_ff == S_IDLE) && req_valid && need_sweep;
         if (csr_valid && csr_ready) begin
            flood_ff <= csr_flood_port;
         end
         if (rsp_valid_ff && !rsp_stall && !commit) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  cmd_ff     <= req_cmd;
                  key_a_ff   <= (req_cmd == CMD_EXPIRE) ? req_expire_mac : req_src_mac;
                  dst_ff     <= req_dst_mac;
                  in_port_ff <= req_in_port;
                  if (need_sweep) begin
                     state_ff  <= S_SWEEP;
                  end else begin
                     state_ff  <= S_WRITE;
                  end
               end
            end
            S_SWEEP: begin
               // capture the token as it leaves the last cell
               if (tok_active[TABLE_ENTRIES-1]) begin
                  res_ff         <= tok[TABLE_ENTRIES];
                  res_src_idx_ff <= src_idx[TABLE_ENTRIES];
                  res_f1_ff      <= f1_idx[TABLE_ENTRIES];
                  res_f2_ff      <= f2_idx[TABLE_ENTRIES];
                  state_ff       <= S_WRITE;
               end
            end
            S_WRITE: begin
               if (commit) begin
                  rsp_valid_ff     <= 1'b1;
                  rsp_out_port_ff  <= res_out_port;
                  rsp_status_ff    <= res_status;
                  rsp_src_added_ff <= res_src_added;
                  rsp_dst_added_ff <= res_dst_added;
                  rsp_removed_ff   <= res_removed;
                  rsp_full_ff      <= res_full;
                  state_ff         <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_port   = rsp_out_port_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_src_added  = rsp_src_added_ff;
   assign rsp_dst_added  = rsp_dst_added_ff;
   assign rsp_removed    = rsp_removed_ff;
   assign rsp_table_full = rsp_full_ff;

`ifndef NO_ASSERTIONS
   // only one search token may be in the row at any time
   a_single_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_active))
      else $error("more than one search token in the cell row");

   // no token may still be walking while entries are written back
   a_quiet_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WRITE) |-> (tok_active == '0) && !launch_ff)
      else $error("write-back while a search is in flight");

   // source and destination inserts must land in different entries
   a_distinct_insert: assert property (@(posedge clock) disable iff (reset)
      (wr.a_set && wr.b_set) |-> (wr_a_idx != wr_b_idx))
      else $error("both write ports aimed at one entry");

   // a token is launched only as a search begins
   a_launch_sweep: assert property (@(posedge clock) disable iff (reset)
      launch_ff |-> (state_ff == S_SWEEP))
      else $error("token launched outside a search");
`endif

endmodule

`default_nettype wire

@@ sim/mac_learning_table_test.sv @@
// Self-checking testbench for the MAC learning and forwarding table.
module mac_learning_table_test;
   import mlt_pkg::*;

   localparam int         ENTRIES    = TABLE_ENTRIES_DEFAULT;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int         POOL_SIZE  = 100;
   localparam int         BLOCK_ITEMS = 320;

   typedef struct packed {
      logic [1:0]        cmd;
      logic [MAC_W-1:0]  dst_mac;
      logic [MAC_W-1:0]  src_mac;
      logic [PORT_W-1:0] in_port;
      logic [MAC_W-1:0]  expire_mac;
   } mac_request;

   typedef struct packed {
      logic [PORT_W-1:0] out_port;
      logic [2:0]        status;
      logic              src_added;
      logic              dst_added;
      logic              removed;
      logic              table_full;
   } forward_result;

   // Forwarding table mirror: predicts one decision per accepted request and
   // checks the decisions that come back, oldest first.
   class forwarding_table_model;
      logic [PORT_W-1:0] flood;
      bit                occupied [ENTRIES];
      logic [MAC_W-1:0]  mac_at   [ENTRIES];
      logic [PORT_W-1:0] port_at  [ENTRIES];
      forward_result     pending_decisions [$];
      int errors, checked, hits, floods, mcast_drops, full_events, removals;

      function new();
         flood = FLOOD_PORT_RESET;
         foreach (occupied[i]) occupied[i] = 1'b0;
         errors = 0; checked = 0; hits = 0; floods = 0;
         mcast_drops = 0; full_events = 0; removals = 0;
      endfunction

      function int lookup(logic [MAC_W-1:0] mac);
         foreach (occupied[i])
            if (occupied[i] && mac_at[i] == mac) return i;
         return -1;
      endfunction

      // Take the lowest free slot; report failure when none is left.
      function bit learn(logic [MAC_W-1:0] mac, logic [PORT_W-1:0] port);
         foreach (occupied[i]) begin
            if (!occupied[i]) begin
               occupied[i] = 1'b1;
               mac_at[i]   = mac;
               port_at[i]  = port;
               return 1'b1;
            end
         end
         return 1'b0;
      endfunction

      function void note_request(mac_request rq);
         forward_result fr;
         int            idx;
         fr = '0;
         fr.status = ST_DONE;
         case (rq.cmd)
            CMD_FRAME: begin
               if (rq.src_mac[MCAST_BIT]) begin
                  fr.status = ST_SRC_MCAST;
               end else begin
                  idx = lookup(rq.src_mac);
                  if (idx >= 0) port_at[idx] = rq.in_port;
                  else if (learn(rq.src_mac, rq.in_port)) fr.src_added = 1'b1;
                  else fr.table_full = 1'b1;
                  if (rq.dst_mac[MCAST_BIT]) begin
                     fr.status = ST_DST_MCAST;
                  end else begin
                     idx = lookup(rq.dst_mac);
                     if (idx >= 0) begin
                        fr.out_port = port_at[idx];
                        fr.status   = ST_HIT;
                     end else begin
                        if (learn(rq.dst_mac, flood)) fr.dst_added = 1'b1;
                        else fr.table_full = 1'b1;
                        fr.out_port = flood;
                        fr.status   = ST_MISS;
                     end
                  end
               end
            end
            CMD_EXPIRE: begin
               idx = lookup(rq.expire_mac);
               if (idx >= 0) begin
                  occupied[idx] = 1'b0;
                  fr.removed    = 1'b1;
               end
            end
            CMD_CLEAR: foreach (occupied[i]) occupied[i] = 1'b0;
            default: ;
         endcase
         pending_decisions.push_back(fr);
      endfunction

      function void check_decision(forward_result got);
         forward_result want;
         if (pending_decisions.size() == 0) begin
            $error("response transaction with no request outstanding");
            errors++;
            return;
         end
         want = pending_decisions.pop_front();
         checked++;
         if (got.status inside {ST_SRC_MCAST, ST_DST_MCAST}) mcast_drops++;
         if (got.status == ST_HIT) hits++;
         if (got.status == ST_MISS) floods++;
         if (got.table_full) full_events++;
         if (got.removed) removals++;
         if (got.out_port !== want.out_port) begin
            $error("out_port: expected %h, got %h", want.out_port, got.out_port);
            errors++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
         end
         if (got.src_added !== want.src_added) begin
            $error("src_added: expected %b, got %b", want.src_added, got.src_added);
            errors++;
         end
         if (got.dst_added !== want.dst_added) begin
            $error("dst_added: expected %b, got %b", want.dst_added, got.dst_added);
            errors++;
         end
         if (got.removed !== want.removed) begin
            $error("removed: expected %b, got %b", want.removed, got.removed);
            errors++;
         end
         if (got.table_full !== want.table_full) begin
            $error("table_full: expected %b, got %b", want.table_full, got.table_full);
            errors++;
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [1:0]        req_cmd = CMD_FRAME;
   logic [MAC_W-1:0]  req_dst_mac = '0;
   logic [MAC_W-1:0]  req_src_mac = '0;
   logic [PORT_W-1:0] req_in_port = '0;
   logic [MAC_W-1:0]  req_expire_mac = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [PORT_W-1:0] rsp_out_port;
   logic [2:0]        rsp_status;
   logic              rsp_src_added;
   logic              rsp_dst_added;
   logic              rsp_removed;
   logic              rsp_table_full;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [PORT_W-1:0] csr_flood_port = '0;

   forwarding_table_model model;
   logic [MAC_W-1:0]      known_macs [POOL_SIZE];
   int unsigned           send_gap_pct = 0;
   int unsigned           recv_stall_pct = 0;
   int unsigned           flood_settings = 1;

   mac_learning_table #(.TABLE_ENTRIES(ENTRIES)) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_dst_mac    (req_dst_mac),
      .req_src_mac    (req_src_mac),
      .req_in_port    (req_in_port),
      .req_expire_mac (req_expire_mac),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_port   (rsp_out_port),
      .rsp_status     (rsp_status),
      .rsp_src_added  (rsp_src_added),
      .rsp_dst_added  (rsp_dst_added),
      .rsp_removed    (rsp_removed),
      .rsp_table_full (rsp_table_full),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_flood_port (csr_flood_port)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Safety net: a hung handshake must not run forever.
   initial begin
      #10_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // Response side: sample the transaction that completes at this edge, then
   // decide the stall for the next cycle. Values read here are pre-edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         model.check_decision({rsp_out_port, rsp_status, rsp_src_added,
                               rsp_dst_added, rsp_removed, rsp_table_full});
      rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
   end

   function automatic logic [MAC_W-1:0] any_mac();
      logic [MAC_W-1:0] m;
      m[47:32] = 16'($urandom());
      m[31:0]  = $urandom();
      return m;
   endfunction

   function automatic logic [MAC_W-1:0] unicast_mac();
      logic [MAC_W-1:0] m;
      m = any_mac();
      m[MCAST_BIT] = 1'b0;
      return m;
   endfunction

   function automatic logic [MAC_W-1:0] multicast_mac();
      logic [MAC_W-1:0] m;
      m = ($urandom_range(0, 1) == 0) ? '1 : any_mac();
      m[MCAST_BIT] = 1'b1;
      return m;
   endfunction

   // Mostly reuse a bounded set of stations so lookups hit and the table
   // fills up; now and then bring in a stranger.
   function automatic logic [MAC_W-1:0] station_mac();
      if ($urandom_range(0, 9) == 0) return unicast_mac();
      return known_macs[$urandom_range(0, POOL_SIZE-1)];
   endfunction

   function automatic logic [PORT_W-1:0] any_port();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return $urandom();
      endcase
   endfunction

   function automatic mac_request frame_req(logic [MAC_W-1:0] src, logic [MAC_W-1:0] dst,
                                            logic [PORT_W-1:0] port);
      return '{cmd: CMD_FRAME, dst_mac: dst, src_mac: src, in_port: port,
               expire_mac: any_mac()};
   endfunction

   function automatic mac_request other_req(logic [1:0] cmd, logic [MAC_W-1:0] mac);
      return '{cmd: cmd, dst_mac: any_mac(), src_mac: any_mac(), in_port: $urandom(),
               expire_mac: mac};
   endfunction

   function automatic mac_request random_req();
      int unsigned      pick;
      logic [MAC_W-1:0] src, dst;
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
         src = ($urandom_range(0, 99) < 6) ? multicast_mac() : station_mac();
         pick = $urandom_range(0, 99);
         if (pick < 8) dst = multicast_mac();
         else if (pick < 13) dst = src;
         else dst = station_mac();
         return frame_req(src, dst, any_port());
      end
      if (pick < 96)
         return other_req(CMD_EXPIRE, ($urandom_range(0, 4) == 0) ? any_mac() : station_mac());
      if (pick < 97) return other_req(CMD_CLEAR, any_mac());
      return other_req(CMD_UNUSED, any_mac());
   endfunction

   // Present one request transaction, with random idle cycles ahead of it,
   // and hold it until the block takes it.
   task automatic send_request(mac_request rq);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_cmd        <= rq.cmd;
      req_dst_mac    <= rq.dst_mac;
      req_src_mac    <= rq.src_mac;
      req_in_port    <= rq.in_port;
      req_expire_mac <= rq.expire_mac;
      do @(posedge clock); while (req_stall);
      model.note_request(rq);
   endtask

   task automatic send_random(int count);
      repeat (count) send_request(random_req());
   endtask

   // Drop valid and wait until every outstanding response has drained.
   task automatic drain();
      req_valid <= 1'b0;
      while (model.pending_decisions.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_flood_port(logic [PORT_W-1:0] value);
      csr_valid      <= 1'b1;
      csr_flood_port <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      model.flood = value;
      flood_settings++;
   endtask

   initial begin
      logic [MAC_W-1:0] sta_lo, sta_hi, sta_c;
      model  = new();
      sta_lo = '0;
      sta_hi = 48'hFEFF_FFFF_FFFF;
      sta_c  = 48'h0200_0000_0001;
      foreach (known_macs[i]) known_macs[i] = unicast_mac();

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Sender gappy, receiver stalling heavily; flood port left at its default.
      send_gap_pct   = 32;
      recv_stall_pct = 49;

      // Directed: field extremes, learn, update, hit, miss, multicast on
      // either side, self-addressed frame, expire hit and miss, clear, and
      // the unused command.
      send_request(frame_req(sta_lo, sta_lo, '0));
      send_request(frame_req(sta_hi, sta_c, '1));
      send_request(frame_req(sta_c, sta_hi, 32'h1234_5678));
      send_request(frame_req(sta_lo, sta_c, 32'd5));
      send_request(frame_req(48'h0100_0000_0000, sta_lo, 32'd7));
      send_request(frame_req('1, sta_hi, 32'd9));
      send_request(frame_req(sta_lo, '1, 32'hA5A5_A5A5));
      send_request(frame_req(48'h0200_0000_0002, 48'h0100_0000_0000, 32'd3));
      send_request(other_req(CMD_EXPIRE, sta_c));
      send_request(other_req(CMD_EXPIRE, sta_c));
      send_request(frame_req(sta_lo, sta_c, 32'd11));
      send_request(frame_req(sta_c, sta_lo, 32'd12));
      send_request(other_req(CMD_UNUSED, sta_hi));
      send_request(other_req(CMD_EXPIRE, '1));
      send_request(other_req(CMD_CLEAR, '0));
      send_request(frame_req(sta_hi, sta_hi, 32'h8000_0001));
      send_request(frame_req(sta_lo, sta_hi, '0));
      send_random(BLOCK_ITEMS);

      // Swap the idling, flood port at its lowest value.
      drain();
      write_flood_port('0);
      send_gap_pct   = 49;
      recv_stall_pct = 32;
      send_random(BLOCK_ITEMS);

      // Back to back with no idling, flood port at its highest value.
      drain();
      write_flood_port('1);
      send_gap_pct   = 0;
      recv_stall_pct = 0;
      send_random(BLOCK_ITEMS);

      // Still no idling, arbitrary flood port.
      drain();
      write_flood_port($urandom());
      send_random(BLOCK_ITEMS);

      drain();
      repeat (ENTRIES + 8) @(posedge clock);

      $display("Checked %0d responses: %0d hits, %0d floods, %0d multicast drops",
               model.checked, model.hits, model.floods, model.mcast_drops);
      $display("Table-full events %0d, removals %0d, flood port settings %0d",
               model.full_events, model.removals, flood_settings);
      if (model.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/mlt_pkg.sv
rtl/mlt_cell.sv
rtl/mac_learning_table.sv
sim/mac_learning_table_test.sv
